// File: hdl/masked_polynomial_pixel_map_assert.svh
// Assertion macros shared by the pixel map modules.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef MASKED_POLYNOMIAL_PIXEL_MAP_ASSERT_SVH
`define MASKED_POLYNOMIAL_PIXEL_MAP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mppm_pkg.sv
// Shared types and constants of the masked polynomial pixel map.
// Used by the controller, the datapath and the top level; no dependencies.
package mppm_pkg;

  localparam int DATA_W      = 32;
  localparam int DEG_W       = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int OUT_TDATA_W = 168;
  localparam int IN_TUSER_W  = 2;
  localparam int MAX_DEGREE_DEF = 4;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_LOW  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_HIGH = 4'd7;

  localparam logic [DEG_W-1:0]         DEGREE_RST = 3'd1;
  localparam logic signed [DATA_W-1:0] COEF1_RST  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN      = 32'sh8000_0000;
  localparam logic [DATA_W-1:0]        CNT_MAX    = 32'hFFFF_FFFF;

  // Bit positions inside in_tuser.
  localparam int TUSER_MASK  = 0;
  localparam int TUSER_START = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted pixel, seed the accumulator
    logic step;    // one Horner multiply-add
    logic finish;  // update statistics and fill the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_hold;  // output register full and not taken this cycle
  } dp_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_STEP   = 3'b010,
    ST_FINISH = 3'b100
  } ctrl_state_t;

endpackage

// File: hdl/mppm_ctrl.sv
// Sequencing controller of the pixel map: accepts a pixel, counts Horner steps,
// then waits for the output register. Depends on mppm_pkg.
`include "masked_polynomial_pixel_map_assert.svh"

module mppm_ctrl
  import mppm_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  localparam int IDX_W = (MAX_DEGREE < 2) ? 1 : $clog2(MAX_DEGREE + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mask,
  output logic             in_ready,
  input  logic [IDX_W-1:0] deg_eff,
  input  dp_sts_t          sts,
  output ctrl_cmd_t        cmd,
  output logic [IDX_W-1:0] coef_idx
);

  ctrl_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic             accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  // In idle the top coefficient seeds the accumulator; while stepping, the
  // coefficient one below the remaining count is added.
  assign coef_idx = (state_r == ST_IDLE) ? deg_eff : step_r - IDX_W'(1);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          step_nxt = deg_eff;
          if (in_mask && (deg_eff != '0)) begin
            state_nxt = ST_STEP;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        step_nxt = step_r - IDX_W'(1);
        if (step_r == IDX_W'(1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_hold) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  `MPPM_ASSERT_NOW(a_step_count_live, state_r == ST_STEP, step_r != '0, "step with zero count")
  `MPPM_ASSERT_NEXT(a_masked_skips_steps, accept && !in_mask, state_r == ST_FINISH, "masked pixel stepped")
  `MPPM_ASSERT_NEXT(a_finish_waits, state_r == ST_FINISH && sts.out_hold, state_r == ST_FINISH, "left finish while output full")

endmodule

// File: hdl/mppm_datapath.sv
// Datapath of the pixel map: configuration registers, Horner multiply-add,
// running statistics and the output register. Depends on mppm_pkg.
`include "masked_polynomial_pixel_map_assert.svh"

module mppm_datapath
  import mppm_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  localparam int IDX_W = (MAX_DEGREE < 2) ? 1 : $clog2(MAX_DEGREE + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  input  logic [DATA_W-1:0]      in_sample,
  input  logic [IN_TUSER_W-1:0]  in_flags,
  input  ctrl_cmd_t              cmd,
  input  logic [IDX_W-1:0]       coef_idx,
  output logic [IDX_W-1:0]       deg_eff,
  output dp_sts_t                sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int NCOEF = MAX_DEGREE + 1;
  localparam int SUM_W = 50;

  logic [DEG_W-1:0]         degree_r;
  logic signed [DATA_W-1:0] coef_r [NCOEF];
  logic signed [DATA_W-1:0] fit_low_r, fit_high_r;

  logic signed [DATA_W-1:0] x_r, acc_r, acc_nxt, value_r;
  logic                     mask_r, start_r, ext_r, out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] min_r, max_r, min_nxt, max_nxt, min_base, max_base;
  logic [DATA_W-1:0]        vcnt_r, ecnt_r, vcnt_nxt, ecnt_nxt, vcnt_base, ecnt_base;
  logic                     outside;

  logic signed [DATA_W-1:0]   coef_rd;
  logic signed [2*DATA_W-1:0] prod, prod_rnd, prod_sh;
  logic signed [SUM_W-1:0]    sum;
  logic signed [DATA_W-1:0]   sum_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r   <= DEGREE_RST;
      fit_low_r  <= Q_MIN;
      fit_high_r <= Q_MAX;
    end else if (cfg_wr) begin
      if (cfg_index == REG_DEGREE) begin
        degree_r <= cfg_data[DEG_W-1:0];
      end
      if (cfg_index == REG_FIT_LOW) begin
        fit_low_r <= $signed(cfg_data);
      end
      if (cfg_index == REG_FIT_HIGH) begin
        fit_high_r <= $signed(cfg_data);
      end
    end
  end

  for (genvar i = 0; i < NCOEF; i++) begin : g_coef
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[i] <= (i == 1) ? COEF1_RST : '0;
      end else if (cfg_wr && (cfg_index == CFG_IDX_W'(int'(REG_COEF0) + i))) begin
        coef_r[i] <= $signed(cfg_data);
      end
    end
  end

  assign deg_eff = (degree_r > DEG_W'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE) : IDX_W'(degree_r);
  assign coef_rd = coef_r[coef_idx];

  // One Horner step: round the Q32.32 product to Q16.16 (ties up), add the
  // coefficient exactly, then clamp to 32 bits.
  always_comb begin
    prod     = x_r * acc_r;
    prod_rnd = prod + 64'sd32768;
    prod_sh  = prod_rnd >>> 16;
    sum      = $signed(prod_sh[SUM_W-1:0]) + SUM_W'(coef_rd);
    if (sum > SUM_W'(Q_MAX)) begin
      sum_sat = Q_MAX;
    end else if (sum < SUM_W'(Q_MIN)) begin
      sum_sat = Q_MIN;
    end else begin
      sum_sat = sum[DATA_W-1:0];
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load) begin
      acc_nxt = coef_rd;
    end else if (cmd.step) begin
      acc_nxt = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.load) begin
      x_r     <= $signed(in_sample);
      mask_r  <= in_flags[TUSER_MASK];
      start_r <= in_flags[TUSER_START];
    end
    if (cmd.finish) begin
      value_r <= mask_r ? acc_r : '0;
      ext_r   <= mask_r & outside;
    end
  end

  // Statistics: a start flag restarts from the cleared values before this pixel.
  assign outside   = (x_r < fit_low_r) || (x_r > fit_high_r);
  assign min_base  = start_r ? Q_MAX : min_r;
  assign max_base  = start_r ? Q_MIN : max_r;
  assign vcnt_base = start_r ? '0 : vcnt_r;
  assign ecnt_base = start_r ? '0 : ecnt_r;

  always_comb begin
    min_nxt  = min_base;
    max_nxt  = max_base;
    vcnt_nxt = vcnt_base;
    ecnt_nxt = ecnt_base;
    if (mask_r) begin
      if (acc_r < min_base) begin
        min_nxt = acc_r;
      end
      if (acc_r > max_base) begin
        max_nxt = acc_r;
      end
      if (vcnt_base != CNT_MAX) begin
        vcnt_nxt = vcnt_base + DATA_W'(1);
      end
      if (outside && (ecnt_base != CNT_MAX)) begin
        ecnt_nxt = ecnt_base + DATA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= Q_MAX;
      max_r  <= Q_MIN;
      vcnt_r <= '0;
      ecnt_r <= '0;
    end else if (cmd.finish) begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      vcnt_r <= vcnt_nxt;
      ecnt_r <= ecnt_nxt;
    end
  end

  // Output register; the statistics registers double as its report fields.
  assign out_valid_nxt = cmd.finish | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.out_hold = out_valid_r & ~out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = {7'd0, ecnt_r, vcnt_r, max_r, min_r, ext_r, value_r};

  `MPPM_ASSERT_NOW(a_finish_slot_free, cmd.finish, !sts.out_hold, "finish into full output")
  `MPPM_ASSERT_NEXT(a_masked_no_ext, cmd.finish && !mask_r, !ext_r && value_r == '0, "masked pixel flagged")
  `MPPM_ASSERT_NEXT(a_masked_no_count, cmd.finish && !mask_r && !start_r, $stable(vcnt_r), "masked pixel counted")

endmodule

// File: hdl/masked_polynomial_pixel_map.sv
// Top level of the masked polynomial pixel map.
// Depends on mppm_pkg, mppm_ctrl and mppm_datapath.
//
// Use: each pixel arrives as one transfer on the in_ channel: in_tdata holds
// the signed Q16.16 sample, in_tuser holds the mask bit and the start-of-image
// flag. For an unmasked pixel the block evaluates the configured polynomial
// with Horner's rule, one saturating multiply-add per cycle on a single shared
// multiplier, and flags a sample outside [fit_low, fit_high]. Each pixel gives
// exactly one transfer on the out_ channel with the value, the flag, the
// running minimum and maximum, and the valid and extrapolated pixel counts.
// For an unmasked pixel the result passes through the Horner steps before it
// reaches out_tvalid; a masked pixel or degree zero skips the Horner steps.
// A new pixel is accepted only after the previous one has been handed to the
// output register; in_tready is high only while the block is idle.
// If the receiver stalls, the result waits in the output register and one
// further pixel may still be accepted and computed; it then waits until the
// register empties. Reset restores the configuration defaults (degree 1,
// identity coefficients, full fit range) and clears the statistics. The
// configuration channel is always ready; write it only while the block is idle.
module masked_polynomial_pixel_map
  import mppm_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  localparam int IDX_W = (MAX_DEGREE < 2) ? 1 : $clog2(MAX_DEGREE + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  // Pixel input channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,   // [31:0] sample
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] mask_on, [1] start_image
  // Result output channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] value, [32] extrapolated,
                                             // [64:33] result_min, [96:65] result_max,
                                             // [128:97] valid_count,
                                             // [160:129] extrap_count, [167:161] zero
);

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] deg_eff;
  logic [IDX_W-1:0] coef_idx;

  // Register writes go straight into the registers, so the channel never stalls.
  assign cfg_ready = 1'b1;

  mppm_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mask  (in_tuser[TUSER_MASK]),
    .in_ready (in_tready),
    .deg_eff  (deg_eff),
    .sts      (sts),
    .cmd      (cmd),
    .coef_idx (coef_idx)
  );

  mppm_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (in_tdata),
    .in_flags  (in_tuser),
    .cmd       (cmd),
    .coef_idx  (coef_idx),
    .deg_eff   (deg_eff),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for masked_polynomial_pixel_map: streams pixels, predicts
// every result transfer with its own Horner evaluator and compares field by field.
// Depends on mppm_pkg and the masked_polynomial_pixel_map RTL; nothing else.
module testbench;
  import mppm_pkg::*;

  // One Q16.16 unit, in which the random spans are counted that keep most values in a range where
  // the polynomial does not saturate on every step.
  localparam int unsigned ONE = 32'd65536;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 16;     // well above the latency of a pixel
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int LONG_HOLD = 150;        // receiver hold-off, in cycles
  localparam int RAND_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 156;
  // Indexes beyond the register list; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              mask_on;
    logic              start_image;
  } pixel_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     extrap;
    logic signed [DATA_W-1:0] low_mark;
    logic signed [DATA_W-1:0] high_mark;
    logic [DATA_W-1:0]        n_valid;
    logic [DATA_W-1:0]        n_extrap;
  } pixel_map_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;        // [31:0] sample
  logic [IN_TUSER_W-1:0] in_tuser = '0;    // [0] mask_on, [1] start_image
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] value, [32] extrapolated,
                                           // [64:33] result_min, [96:65] result_max,
                                           // [128:97] valid_count, [160:129] extrap_count

  // Pixels waiting to be offered, and the predicted result of every pixel that
  // the block has taken but not yet answered, oldest first.
  pixel_t pixels_to_send[$];
  pixel_map_t pixel_maps_due[$];

  // Private copy of the configuration and of the running statistics.
  logic [DEG_W-1:0] cfg_degree;
  logic signed [DATA_W-1:0] cfg_coef[5];
  logic signed [DATA_W-1:0] cfg_fit_lo, cfg_fit_hi;
  logic signed [DATA_W-1:0] stat_min, stat_max;
  logic [DATA_W-1:0] stat_valid, stat_extrap;

  // Idle percentages of the two sides; only the stimulus process changes them.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int pixels_in = 0;
  int masked_in = 0;
  int starts_in = 0;
  int settings_used = 0;
  int long_holds = 0;

  masked_polynomial_pixel_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_stats();
    stat_min = Q_MAX;
    stat_max = Q_MIN;
    stat_valid = '0;
    stat_extrap = '0;
  endfunction

  function automatic void restore_defaults();
    cfg_degree = DEGREE_RST;
    cfg_coef[0] = '0;
    cfg_coef[1] = COEF1_RST;
    cfg_coef[2] = '0;
    cfg_coef[3] = '0;
    cfg_coef[4] = '0;
    cfg_fit_lo = Q_MIN;
    cfg_fit_hi = Q_MAX;
    clear_stats();
  endfunction

  // Mirrors a register write into the private configuration. Indexes past the
  // register list fall through and change nothing.
  function automatic void latch_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    if (idx == REG_DEGREE) begin
      cfg_degree = data[DEG_W-1:0];
    end else if (idx == REG_FIT_LOW) begin
      cfg_fit_lo = data;
    end else if (idx == REG_FIT_HIGH) begin
      cfg_fit_hi = data;
    end else if (idx >= REG_COEF0 && idx <= REG_COEF0 + MAX_DEGREE_DEF) begin
      cfg_coef[idx - REG_COEF0] = data;
    end
  endfunction

  // One Horner step: the Q32.32 product is rounded half up to Q16.16, then the
  // coefficient is added and the sum clamped to the 32-bit range.
  function automatic logic signed [DATA_W-1:0] horner_mac(
    input logic signed [DATA_W-1:0] x,
    input logic signed [DATA_W-1:0] acc,
    input logic signed [DATA_W-1:0] c
  );
    logic signed [63:0] xw, aw, cw, prod, sum;
    xw = x;
    aw = acc;
    cw = c;
    prod = xw * aw + 64'sd32768;
    sum = (prod >>> 16) + cw;
    if (sum > Q_MAX) return Q_MAX;
    if (sum < Q_MIN) return Q_MIN;
    return sum[DATA_W-1:0];
  endfunction

  // Result of one pixel, updating the running statistics on the way.
  function automatic pixel_map_t map_pixel(pixel_t px);
    pixel_map_t r;
    logic signed [DATA_W-1:0] x;
    int top;
    x = px.sample;
    if (px.start_image) clear_stats();
    r.value = '0;
    r.extrap = 1'b0;
    if (px.mask_on) begin
      top = (cfg_degree > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : int'(cfg_degree);
      r.value = cfg_coef[top];
      for (int j = top - 1; j >= 0; j--) r.value = horner_mac(x, r.value, cfg_coef[j]);
      if (r.value < stat_min) stat_min = r.value;
      if (r.value > stat_max) stat_max = r.value;
      // Bounds are compared as they stand, so an inverted range flags everything.
      if (x < cfg_fit_lo || x > cfg_fit_hi) begin
        r.extrap = 1'b1;
        if (stat_extrap != CNT_MAX) stat_extrap++;
      end
      if (stat_valid != CNT_MAX) stat_valid++;
    end
    r.low_mark = stat_min;
    r.high_mark = stat_max;
    r.n_valid = stat_valid;
    r.n_extrap = stat_extrap;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Writes one register; the caller starts at a clock edge, and a run of writes
  // keeps cfg_valid high from one transfer to the next.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    latch_reg(idx, data);
  endtask

  // Programs every register; c holds coef4 in its top slice down to coef0.
  task automatic program_map(
    logic [DATA_W-1:0] deg_word,
    logic [MAX_DEGREE_DEF:0][DATA_W-1:0] c,
    logic [DATA_W-1:0] lo,
    logic [DATA_W-1:0] hi,
    bit poke_spare
  );
    @(posedge clk);
    write_reg(REG_DEGREE, deg_word);
    for (int i = 0; i <= MAX_DEGREE_DEF; i++)
      write_reg(CFG_IDX_W'(int'(REG_COEF0) + i), c[i]);
    write_reg(REG_FIT_LOW, lo);
    write_reg(REG_FIT_HIGH, hi);
    if (poke_spare)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(logic [DATA_W-1:0] sample, logic mask_on, logic start_image);
    pixel_t px;
    px.sample = sample;
    px.mask_on = mask_on;
    px.start_image = start_image;
    pixels_to_send.push_back(px);
  endtask

  // The sender holds back here until every predicted result has been taken,
  // then waits out SETTLE_CYCLES so the block is idle before any register write.
  task automatic drain_pixels();
    while (pixels_to_send.size() != 0 || in_tvalid || pixel_maps_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A value within +/- span Q16.16 units.
  function automatic logic [DATA_W-1:0] near_zero(int unsigned span);
    return $urandom_range(0, 2 * span * ONE) - span * ONE;
  endfunction

  function automatic logic [DATA_W-1:0] rand_coef();
    case ($urandom_range(7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom();
      default: return near_zero(4);
    endcase
  endfunction

  // Samples cluster near zero and around the fit bounds, with some extremes
  // and some fully random words so that every bit toggles.
  function automatic logic [DATA_W-1:0] rand_sample(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
    case ($urandom_range(9))
      0: return $urandom_range(1) ? Q_MAX : Q_MIN;
      1: return $urandom();
      2: return lo + $urandom_range(2) - 1;
      3: return hi + $urandom_range(2) - 1;
      default: return near_zero(3);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the head of pixels_to_send and holds it until it transfers.
  // The prediction is made at the transfer edge, so it sees exactly the
  // configuration the block uses for that pixel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t px;
    logic [IN_TUSER_W-1:0] tu;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        px = pixels_to_send.pop_front();
        pixel_maps_due.push_back(map_pixel(px));
        pixels_in++;
        if (!px.mask_on) masked_in++;
        if (px.start_image) starts_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          px = pixels_to_send[0];
          tu = '0;
          tu[TUSER_MASK] = px.mask_on;
          tu[TUSER_START] = px.start_image;
          in_tvalid <= 1'b1;
          in_tdata <= px.sample;
          in_tuser <= tu;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and receiver: checks each result transfer against the oldest
  // prediction and drives out_tready. Twice in the run the receiver holds
  // out_tready low while the driver keeps offering, so the block fills
  // its output register, holds one further pixel and has to stall its input.
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string why, pixel_map_t want, pixel_map_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("result %0d, %s: expected value=%h ext=%b min=%h max=%h valid=%0d extrap=%0d",
               results_seen, why, want.value, want.extrap, want.low_mark, want.high_mark,
               want.n_valid, want.n_extrap);
      $display("  actual value=%h ext=%b min=%h max=%h valid=%0d extrap=%0d",
               got.value, got.extrap, got.low_mark, got.high_mark, got.n_valid, got.n_extrap);
    end
  endtask

  always @(posedge clk) begin
    pixel_map_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[31:0];
        got.extrap = out_tdata[32];
        got.low_mark = out_tdata[64:33];
        got.high_mark = out_tdata[96:65];
        got.n_valid = out_tdata[128:97];
        got.n_extrap = out_tdata[160:129];
        if (pixel_maps_due.size() == 0) begin
          flag_mismatch("no pixel pending", '0, got);
        end else begin
          want = pixel_maps_due.pop_front();
          if (got != want) flag_mismatch("field mismatch", want, got);
          else if (out_tdata[OUT_TDATA_W-1:161] != '0) flag_mismatch("padding set", want, got);
        end
        results_seen++;
        if (results_seen == 400 || results_seen == 1300) begin
          hold_left = LONG_HOLD;
          long_holds++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a stretch without any transfer on any channel ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pixel_maps_due.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [MAX_DEGREE_DEF:0][DATA_W-1:0] c;
    logic [DATA_W-1:0] lo, hi, dw;
    int deg;

    restore_defaults();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part and the first random phases: sender idles rarely,
    // receiver often.
    send_idle_pct = 31;
    recv_idle_pct = 71;

    // Reset configuration, an identity map over the full range. The first
    // pixel is masked, so the statistics still read their cleared values.
    send_pixel(32'd12345, 1'b0, 1'b0);
    send_pixel(Q_MIN, 1'b1, 1'b0);
    send_pixel(Q_MAX, 1'b1, 1'b0);
    send_pixel('0, 1'b1, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_pixel(32'h0000_8000, 1'b1, 1'b0);
    send_pixel(Q_MAX, 1'b0, 1'b0);
    send_pixel(ONE, 1'b1, 1'b1);
    drain_pixels();

    // Full degree with extreme coefficients, so Horner steps can saturate,
    // and a narrow fit range probed at and just beyond both bounds.
    c = {Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX};
    program_map(MAX_DEGREE_DEF, c, -ONE, ONE, 1'b0);
    send_pixel(-ONE, 1'b1, 1'b0);
    send_pixel(ONE, 1'b1, 1'b0);
    send_pixel(-ONE - 1, 1'b1, 1'b0);
    send_pixel(ONE + 1, 1'b1, 1'b0);
    send_pixel(Q_MAX, 1'b1, 1'b0);
    send_pixel(Q_MIN, 1'b0, 1'b0);       // masked and outside: no flag
    send_pixel('0, 1'b0, 1'b1);          // clear on a masked pixel
    send_pixel(32'h0001_8000, 1'b1, 1'b0);
    drain_pixels();

    // Degree zero gives coef0 for any sample; the range is inverted, so every
    // unmasked pixel is flagged; a write past the register list is ignored.
    c = {Q_MIN, Q_MAX, Q_MIN, Q_MAX, 32'h0003_0000};
    program_map('0, c, ONE, -ONE, 1'b1);
    send_pixel('0, 1'b1, 1'b0);
    send_pixel(Q_MIN, 1'b1, 1'b0);
    send_pixel(Q_MAX, 1'b1, 1'b1);
    drain_pixels();

    // A degree above the maximum is treated as the maximum. Small coefficients
    // exercise the rounding of the product, ties included.
    c = {32'h0000_8000, -ONE, 32'h0, 2 * ONE, 32'hFFFF_8000};
    program_map(DATA_W'({DEG_W{1'b1}}), c, Q_MIN, Q_MAX, 1'b0);
    send_pixel(2 * ONE, 1'b1, 1'b0);
    send_pixel(-3 * ONE, 1'b1, 1'b0);
    send_pixel(32'h0000_0001, 1'b1, 1'b0);
    send_pixel(32'hFFFF_8000, 1'b1, 1'b0);
    send_pixel(Q_MIN, 1'b1, 1'b0);
    drain_pixels();

    // Random phases, each under a fresh configuration. Each phase opens an
    // image with a start flag; a few more start flags fall inside it.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 31;
      end else if (p == 2 * RAND_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      deg = ($urandom_range(5) == 0) ? $urandom_range(MAX_DEGREE_DEF + 1, (1 << DEG_W) - 1)
                                     : $urandom_range(MAX_DEGREE_DEF);
      // Upper bits of the degree word are sometimes noise; only the low bits count.
      dw = ($urandom_range(3) == 0) ? $urandom() : '0;
      dw[DEG_W-1:0] = DEG_W'(deg);
      for (int i = 0; i <= MAX_DEGREE_DEF; i++) c[i] = rand_coef();
      case ($urandom_range(3))
        0: begin
          lo = Q_MIN;
          hi = Q_MAX;
        end
        1: begin
          lo = -$urandom_range(0, 2 * ONE);
          hi = $urandom_range(0, 2 * ONE);
        end
        2: begin
          lo = $urandom();
          hi = $urandom();
        end
        default: begin
          lo = $urandom_range(1, 2 * ONE);
          hi = -$urandom_range(1, 2 * ONE);
        end
      endcase
      program_map(dw, c, lo, hi, (p % 3) == 0);
      for (int k = 0; k < PIXELS_PER_PHASE; k++)
        send_pixel(rand_sample(lo, hi), $urandom_range(99) < 85,
                   k == 0 || $urandom_range(99) < 3);
      drain_pixels();
    end

    while (pixel_maps_due.size() != 0)
      flag_mismatch("result never arrived", pixel_maps_due.pop_front(), '0);

    $display("Mapped %0d pixels (%0d masked, %0d opening an image) under %0d register settings,",
             pixels_in, masked_in, starts_in, settings_used);
    $display("checked %0d results across %0d long output stalls; %0d mismatches.",
             results_seen, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/mppm_pkg.sv
hdl/mppm_ctrl.sv
hdl/mppm_datapath.sv
hdl/masked_polynomial_pixel_map.sv
dv/testbench.sv
